// ===== rtl/bel_pkg.sv =====
// Package for the beat envelope LED drive block: beat payload types,
// microcode encoding and program ROM, shared arithmetic helpers.
// No dependencies.
package bel_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int LEVEL_WIDTH = 8;
   localparam int HUE_WIDTH = 7;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int UCODE_DEPTH = 8;
   localparam int STEP_WIDTH = $clog2(UCODE_DEPTH);

   localparam logic [LEVEL_WIDTH-1:0] BRIGHTNESS_RESET = 8'd100;
   localparam logic [HUE_WIDTH-1:0] HUE_QUIET = 7'd100;
   localparam logic [0:0] REG_BRIGHTNESS = 1'b0;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] band_level_7;
      logic [LEVEL_WIDTH-1:0] band_level_6;
      logic [LEVEL_WIDTH-1:0] band_level_5;
      logic [LEVEL_WIDTH-1:0] band_level_4;
      logic [LEVEL_WIDTH-1:0] band_level_3;
      logic [LEVEL_WIDTH-1:0] band_level_2;
      logic [LEVEL_WIDTH-1:0] band_level_1;
      logic [LEVEL_WIDTH-1:0] band_level_0;
   } req_type;

   typedef struct packed {
      logic [HUE_WIDTH-1:0]   pixel_hue;
      logic [LEVEL_WIDTH-1:0] pixel_value;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_BASE_MUL,
      OP_BASE_UPD,
      OP_DRIVE,
      OP_ENV_MUL,
      OP_ENV_UPD,
      OP_OUT_MUL,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_REQ,
      COND_RSP
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     last;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } seq_type;

   function automatic ucode_type ucode_rom(input logic [STEP_WIDTH-1:0] step);
      ucode_type w;
      unique case (step)
         3'd0: w = '{op: OP_LOAD,     cond: COND_REQ,  last: 1'b0};
         3'd1: w = '{op: OP_BASE_MUL, cond: COND_NONE, last: 1'b0};
         3'd2: w = '{op: OP_BASE_UPD, cond: COND_NONE, last: 1'b0};
         3'd3: w = '{op: OP_DRIVE,    cond: COND_NONE, last: 1'b0};
         3'd4: w = '{op: OP_ENV_MUL,  cond: COND_NONE, last: 1'b0};
         3'd5: w = '{op: OP_ENV_UPD,  cond: COND_NONE, last: 1'b0};
         3'd6: w = '{op: OP_OUT_MUL,  cond: COND_NONE, last: 1'b0};
         3'd7: w = '{op: OP_OUT,      cond: COND_RSP,  last: 1'b1};
         default: w = '{op: OP_LOAD, cond: COND_REQ, last: 1'b0};
      endcase
      return w;
   endfunction

   // floor(x / 255), exact for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

endpackage

// ===== rtl/beat_envelope_led_drive.sv =====
// Top level of the beat envelope LED drive: sequencer, datapath and CSR block.
// Depends on bel_pkg, bel_csr, bel_sequencer, bel_datapath.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one spectrum frame per beat,
//   eight low-band levels. rsp channel (rsp_valid/rsp_ready/rsp_data): one
//   beat per frame with pixel_hue and pixel_value.
//   APB port: register 0 at address 0 is brightness (8 bits, reset 100).
//   Write it only while the block is idle.
// Timing:
//   A frame runs through an 8-step microprogram on one shared multiplier;
//   rsp_valid is registered, set as the last (OUT) step fires; a new frame
//   waits for the previous one's last step. req_ready is high only on the
//   load step. The result sits in an output register, so the next frame is
//   taken and computed while it waits; if the receiver stalls, the sequencer
//   holds on its last step until the output register frees up.
// Reset:
//   Synchronous, active high: baseline and envelope go to zero, brightness
//   to 100, no result pending.
module beat_envelope_led_drive
   import bel_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [LEVEL_WIDTH-1:0] brightness;
   seq_type                seq;
   logic                   rsp_free;

   assign rsp_free = !rsp_valid || rsp_ready;

   bel_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .brightness (brightness)
   );

   bel_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .seq       (seq)
   );

   bel_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .seq        (seq),
      .req_data   (req_data),
      .brightness (brightness),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/bel_csr.sv =====
// Configuration register file for the beat envelope LED drive (APB-style).
// Depends on bel_pkg.
module bel_csr
   import bel_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [LEVEL_WIDTH-1:0]    brightness
);

   logic [LEVEL_WIDTH-1:0] brightness_ff;
   logic                   wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_BRIGHTNESS);

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
      end else if (wr_hit) begin
         brightness_ff <= pwdata[LEVEL_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_BRIGHTNESS) begin
         prdata = {{(CSR_DATA_WIDTH-LEVEL_WIDTH){1'b0}}, brightness_ff};
      end
   end

   assign brightness = brightness_ff;

endmodule

// ===== rtl/bel_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup and jump control.
// Depends on bel_pkg.
module bel_sequencer
   import bel_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_free,
   output logic    req_ready,
   output seq_type seq
);

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   ucode_type             word;
   logic                  advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = ucode_rom(step_ff);
      req_ready = (word.cond == COND_REQ) && !reset;
      unique case (word.cond)
         COND_NONE: advance = 1'b1;
         COND_REQ:  advance = req_valid && req_ready;
         COND_RSP:  advance = rsp_free;
         default:   advance = 1'b0;
      endcase
      step_in = step_ff;
      if (advance) begin
         step_in = word.last ? '0 : step_ff + 1'b1;
      end
      seq.op = word.op;
      seq.fire = advance;
   end

endmodule

// ===== rtl/bel_datapath.sv =====
// Datapath: band average, shared multiplier, rounding blend, drive and output stage.
// Depends on bel_pkg; driven by bel_sequencer control.
module bel_datapath
   import bel_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  seq_type                seq,
   input  req_type                req_data,
   input  logic [LEVEL_WIDTH-1:0] brightness,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   localparam int W = LEVEL_WIDTH + FRAC_BITS;
   localparam int PW = W + FRAC_BITS + 3;
   localparam longint unsigned COEF_BASE = ((64'd3 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam longint unsigned COEF_ATTACK = ((64'd13 << FRAC_BITS) + 64'd10) / 64'd20;
   localparam longint unsigned COEF_DECAY = ((64'd11 << FRAC_BITS) + 64'd25) / 64'd50;
   localparam logic [W-1:0] FULL_Q = {8'hFF, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] HALF_Q = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   logic [LEVEL_WIDTH-1:0]  level_ff;
   logic [LEVEL_WIDTH-1:0]  drive_ff;
   logic [W-1:0]            base_ff;
   logic [W-1:0]            env_ff;
   logic signed [PW-1:0]    prod_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic [LEVEL_WIDTH+2:0]  band_sum;
   logic signed [W:0]       mul_a;
   logic [FRAC_BITS:0]      mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [W:0]       env_diff;
   logic signed [PW-1:0]    rnd_full;
   logic signed [W+1:0]     blend_sum;
   logic [W-1:0]            blend_x;
   logic [W-1:0]            blend_r;
   logic [LEVEL_WIDTH-1:0]  base_int;
   logic [LEVEL_WIDTH-1:0]  excess;
   logic [LEVEL_WIDTH+2:0]  drive7;
   logic [LEVEL_WIDTH-1:0]  drive;
   logic [15:0]             hue_p;
   logic [LEVEL_WIDTH-1:0]  hue_q;
   logic [LEVEL_WIDTH-1:0]  value_q;

   assign band_sum = 11'(req_data.band_level_0) + 11'(req_data.band_level_1)
                   + 11'(req_data.band_level_2) + 11'(req_data.band_level_3)
                   + 11'(req_data.band_level_4) + 11'(req_data.band_level_5)
                   + 11'(req_data.band_level_6) + 11'(req_data.band_level_7);

   assign env_diff = $signed({1'b0, drive_ff, {FRAC_BITS{1'b0}}}) - $signed({1'b0, env_ff});

   always_comb begin
      mul_a = $signed({1'b0, level_ff, {FRAC_BITS{1'b0}}}) - $signed({1'b0, base_ff});
      mul_b = COEF_BASE[FRAC_BITS:0];
      unique case (seq.op)
         OP_ENV_MUL: begin
            mul_a = env_diff;
            mul_b = (!env_diff[W] && (env_diff != '0)) ? COEF_ATTACK[FRAC_BITS:0]
                                                       : COEF_DECAY[FRAC_BITS:0];
         end
         OP_OUT_MUL: begin
            mul_a = $signed({1'b0, env_ff});
            mul_b = {{(FRAC_BITS+1-LEVEL_WIDTH){1'b0}}, brightness};
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // round half up, then clamp to 0..FULL_Q
   assign rnd_full = $signed(prod_ff + $signed(HALF_Q)) >>> FRAC_BITS;
   assign blend_x = (seq.op == OP_ENV_UPD) ? env_ff : base_ff;
   assign blend_sum = $signed({2'b00, blend_x}) + $signed(rnd_full[W+1:0]);

   always_comb begin
      if (blend_sum[W+1]) begin
         blend_r = '0;
      end else if (blend_sum[W:0] > {1'b0, FULL_Q}) begin
         blend_r = FULL_Q;
      end else begin
         blend_r = blend_sum[W-1:0];
      end
   end

   assign base_int = base_ff[W-1:FRAC_BITS];
   assign excess = (level_ff > base_int) ? (level_ff - base_int) : '0;
   assign drive7 = 11'(excess) * 11'd7;
   assign drive = (drive7 > 11'd255) ? 8'd255 : drive7[LEVEL_WIDTH-1:0];

   assign hue_p = 16'(env_ff[W-1:FRAC_BITS]) * 16'd100;
   assign hue_q = div255(hue_p);
   assign value_q = div255(prod_ff[FRAC_BITS+15:FRAC_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         env_ff <= '0;
      end else if (seq.fire) begin
         if (seq.op == OP_BASE_UPD) begin
            base_ff <= blend_r;
         end
         if (seq.op == OP_ENV_UPD) begin
            env_ff <= blend_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq.fire) begin
         unique case (seq.op)
            OP_LOAD:     level_ff <= band_sum[LEVEL_WIDTH+2:3];
            OP_DRIVE:    drive_ff <= drive;
            OP_BASE_MUL: prod_ff <= mul_p;
            OP_ENV_MUL:  prod_ff <= mul_p;
            OP_OUT_MUL:  prod_ff <= mul_p;
            OP_OUT: begin
               rsp_data_ff.pixel_hue <= HUE_QUIET - hue_q[HUE_WIDTH-1:0];
               rsp_data_ff.pixel_value <= value_q;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq.fire && (seq.op == OP_OUT)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== sim/tb_beat_envelope_led_drive.sv =====
// Self-checking testbench for beat_envelope_led_drive: spectrum frames in, pixel beats out,
// each beat checked against an in-bench envelope predictor; brightness set over APB.
// Depends on bel_pkg and the beat_envelope_led_drive RTL.
`timescale 1ns / 100ps

module tb_beat_envelope_led_drive;
   import bel_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int STATE_WIDTH = LEVEL_WIDTH + FRAC;
   localparam longint FULL_SCALE = longint'(255) << FRAC;
   localparam longint HALF_LSB = longint'(1) << (FRAC - 1);
   localparam longint COEF_BASELINE = ((longint'(3) << FRAC) + 50) / 100;
   localparam longint COEF_ATTACK = ((longint'(13) << FRAC) + 10) / 20;
   localparam longint COEF_DECAY = ((longint'(11) << FRAC) + 25) / 50;
   localparam logic [CSR_ADDR_WIDTH-1:0] BRIGHTNESS_ADDR = CSR_ADDR_WIDTH'(4 * REG_BRIGHTNESS);
   localparam logic [CSR_ADDR_WIDTH-1:0] RESERVED_ADDR =
      CSR_ADDR_WIDTH'(4 * (REG_BRIGHTNESS + 1));
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   logic [STATE_WIDTH-1:0] baseline_q = '0;
   logic [STATE_WIDTH-1:0] envelope_q = '0;
   logic [LEVEL_WIDTH-1:0] brightness_cfg = BRIGHTNESS_RESET;

   rsp_type pending_pixels[$];
   int mismatch_count = 0;
   int send_gap_pct = 19;
   int stall_pct = 70;
   int hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   beat_envelope_led_drive dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   function automatic logic [STATE_WIDTH-1:0] blend_toward(input longint x, input longint t,
                                                           input longint coef);
      longint stepv;
      longint r;
      stepv = ((t - x) * coef + HALF_LSB) >>> FRAC;
      r = x + stepv;
      if (r < 0) r = 0;
      if (r > FULL_SCALE) r = FULL_SCALE;
      return STATE_WIDTH'(r);
   endfunction

   function automatic rsp_type follow_envelope(input req_type frame);
      int unsigned band_sum;
      longint level;
      longint base_int;
      longint drive;
      longint target;
      longint env_int;
      rsp_type pixel;
      band_sum = frame.band_level_0 + frame.band_level_1 + frame.band_level_2
               + frame.band_level_3 + frame.band_level_4 + frame.band_level_5
               + frame.band_level_6 + frame.band_level_7;
      level = band_sum >> 3;
      baseline_q = blend_toward(baseline_q, level << FRAC, COEF_BASELINE);
      base_int = baseline_q >> FRAC;
      drive = (level > base_int) ? (level - base_int) * 7 : 0;
      if (drive > 255) drive = 255;
      target = drive << FRAC;
      if (target > longint'(envelope_q))
         envelope_q = blend_toward(envelope_q, target, COEF_ATTACK);
      else
         envelope_q = blend_toward(envelope_q, target, COEF_DECAY);
      env_int = envelope_q >> FRAC;
      pixel.pixel_hue = HUE_WIDTH'(longint'(HUE_QUIET) - env_int * 100 / 255);
      pixel.pixel_value = LEVEL_WIDTH'(longint'(brightness_cfg) * longint'(envelope_q)
                                       / FULL_SCALE);
      return pixel;
   endfunction

   function automatic req_type make_frame(input int lo, input int hi);
      logic [8*LEVEL_WIDTH-1:0] raw;
      for (int i = 0; i < 8; i++) begin
         raw[i*LEVEL_WIDTH +: LEVEL_WIDTH] = LEVEL_WIDTH'($urandom_range(lo, hi));
      end
      return req_type'(raw);
   endfunction

   task automatic send_frame(input req_type frame);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(follow_envelope(frame));
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == BRIGHTNESS_ADDR) brightness_cfg = data[LEVEL_WIDTH-1:0];
   endtask

   task automatic check_brightness();
      logic [CSR_DATA_WIDTH-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= BRIGHTNESS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== CSR_DATA_WIDTH'(brightness_cfg)) begin
         $display("%0t brightness readback: expected %0d, actual %0d",
                  $time, brightness_cfg, readback);
         mismatch_count++;
      end
   endtask

   task automatic write_brightness(input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write(BRIGHTNESS_ADDR, data);
      check_brightness();
   endtask

   task automatic send_random_traffic(input int frame_goal);
      int sent;
      int quiet_len;
      int burst_len;
      sent = 0;
      while (sent < frame_goal) begin
         if ($urandom_range(0, 99) < 80) begin
            quiet_len = $urandom_range(2, 12);
            burst_len = $urandom_range(1, 4);
            repeat (quiet_len) send_frame(make_frame(0, $urandom_range(8, 60)));
            repeat (burst_len) send_frame(make_frame($urandom_range(60, 200), 255));
            sent += quiet_len + burst_len;
         end else begin
            send_frame(make_frame(0, 255));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input int gap, input int stall,
                            input logic [CSR_DATA_WIDTH-1:0] bright, input int frames);
      write_brightness(bright);
      send_gap_pct = gap;
      stall_pct = stall;
      send_random_traffic(frames);
      drain_pixels();
   endtask

   task automatic test_reset_values();
      check_brightness();
   endtask

   task automatic test_directed_frames();
      send_frame(req_type'(64'h0));
      repeat (12) send_frame(req_type'({8{8'hFF}}));
      repeat (4) send_frame(req_type'(64'h0));
      send_frame(req_type'({8{8'hAA}}));
      send_frame(req_type'({8{8'h55}}));
      send_frame(req_type'({4{16'h00FF}}));
      send_frame(req_type'({4{16'hFF00}}));
      send_frame(req_type'(64'h0001_0101_0101_0101));
      drain_pixels();
   endtask

   task automatic test_brightness_sweep();
      logic [CSR_DATA_WIDTH-1:0] settings [5];
      settings = '{32'd0, 32'd255, 32'd1, 32'hFFFF_FF80, 32'd0};
      settings[4] = $urandom;
      foreach (settings[i]) begin
         write_brightness(settings[i]);
         // no register behind this address: brightness must stay put
         csr_write(RESERVED_ADDR, $urandom);
         check_brightness();
         repeat (6) send_frame(make_frame(0, 40));
         repeat (4) send_frame(make_frame(180, 255));
         repeat (4) send_frame(make_frame(0, 255));
         drain_pixels();
      end
   endtask

   task automatic test_output_backpressure();
      send_gap_pct = 0;
      hold_request = 150;
      repeat (16) send_frame(make_frame(0, 255));
      drain_pixels();
   endtask

   task automatic test_random_traffic();
      run_phase(19, 70, $urandom, 230);
      run_phase(70, 19, $urandom, 230);
      run_phase(0, 0, 32'd255, 230);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t pixel beat with none expected: hue %0d value %0d",
                     $time, rsp_data.pixel_hue, rsp_data.pixel_value);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_hue !== want.pixel_hue) begin
               $display("%0t pixel_hue: expected %0d, actual %0d",
                        $time, want.pixel_hue, rsp_data.pixel_hue);
               mismatch_count++;
            end
            if (rsp_data.pixel_value !== want.pixel_value) begin
               $display("%0t pixel_value: expected %0d, actual %0d",
                        $time, want.pixel_value, rsp_data.pixel_value);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
         $display("FAIL beat_envelope_led_drive");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_frames();
      test_brightness_sweep();
      test_output_backpressure();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("PASS beat_envelope_led_drive");
      end else begin
         $display("FAIL beat_envelope_led_drive");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bel_pkg.sv
rtl/bel_csr.sv
rtl/bel_sequencer.sv
rtl/bel_datapath.sv
rtl/beat_envelope_led_drive.sv
sim/tb_beat_envelope_led_drive.sv
